/* sv/dtlv_pkg.sv */
// Shared types and constants of the drone ID element parser.
// Used by dtlv_core, dtlv_queue and drone_id_tlv_element_parser; no dependencies.
package dtlv_pkg;

    // Default count of identifier characters emitted per record
    localparam int ID_CHARS_DEFAULT = 20;
    // Offset of the first record inside the element
    localparam logic [7:0] FIRST_RECORD = 8'd6;
    // Entries in the result queue (power of two, at least 4)
    localparam int QUEUE_DEPTH = 4;

    // Record type codes
    localparam logic [7:0] TYPE_OPID    = 8'd2;
    localparam logic [7:0] TYPE_UAVID   = 8'd3;
    localparam logic [7:0] TYPE_LAT     = 8'd4;
    localparam logic [7:0] TYPE_LON     = 8'd5;
    localparam logic [7:0] TYPE_ALT     = 8'd6;
    localparam logic [7:0] TYPE_HEIGHT  = 8'd7;
    localparam logic [7:0] TYPE_OPLAT   = 8'd8;
    localparam logic [7:0] TYPE_OPLON   = 8'd9;
    localparam logic [7:0] TYPE_SPEED   = 8'd10;
    localparam logic [7:0] TYPE_HEADING = 8'd11;

    // Result kind codes
    localparam logic [3:0] KIND_OPID    = 4'd0;
    localparam logic [3:0] KIND_UAVID   = 4'd1;
    localparam logic [3:0] KIND_LAT     = 4'd2;
    localparam logic [3:0] KIND_LON     = 4'd3;
    localparam logic [3:0] KIND_ALT     = 4'd4;
    localparam logic [3:0] KIND_HEIGHT  = 4'd5;
    localparam logic [3:0] KIND_OPLAT   = 4'd6;
    localparam logic [3:0] KIND_OPLON   = 4'd7;
    localparam logic [3:0] KIND_SPEED   = 4'd8;
    localparam logic [3:0] KIND_HEADING = 4'd9;
    localparam logic [3:0] KIND_END     = 4'd10;

    // Parser phase codes
    localparam logic [1:0] PHASE_GAP   = 2'd0;
    localparam logic [1:0] PHASE_TYPE  = 2'd1;
    localparam logic [1:0] PHASE_VALUE = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [4:0]         char_index;
        logic signed [31:0] value;
        logic               run_end;
    } out_t;

    // Results produced by one input beat: zero, one or two
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } emit_t;

endpackage

/* sv/dtlv_core.sv */
// Record parser state and per-byte result decode for the drone ID element parser.
// Depends on dtlv_pkg.
module dtlv_core #(
    parameter int ID_CHARS = dtlv_pkg::ID_CHARS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  dtlv_pkg::in_t    beat,
    output dtlv_pkg::emit_t  emit
);

    localparam logic [7:0] IdLimit = 8'(ID_CHARS);

    logic [7:0]  byte_offset_reg,       byte_offset_next;
    logic [7:0]  element_length_reg,    element_length_next;
    logic [8:0]  next_record_start_reg, next_record_start_next;
    logic [7:0]  record_type_reg,       record_type_next;
    logic [7:0]  record_length_reg,     record_length_next;
    logic [7:0]  value_position_reg,    value_position_next;
    logic [31:0] field_shift_reg,       field_shift_next;
    logic [1:0]  phase_reg,             phase_next;

    logic [7:0]  len_eff;
    logic [7:0]  vp_inc;
    logic [7:0]  vp_char;
    logic [31:0] shifted;
    logic [2:0]  field_size;
    logic [3:0]  field_kind;
    logic        numeric;
    logic        val_hit;
    logic [3:0]  val_kind;
    logic [4:0]  val_index;
    logic [31:0] val_value;
    dtlv_pkg::out_t val_res;
    dtlv_pkg::out_t end_res;

    always_comb
    begin
        len_eff    = (byte_offset_reg == 8'd1) ? beat.data_byte : element_length_reg;
        vp_inc     = value_position_reg + 8'd1;
        vp_char    = value_position_reg - 8'd6;
        shifted    = {field_shift_reg[23:0], beat.data_byte};
        field_size = 3'd0;
        field_kind = dtlv_pkg::KIND_LAT;
        numeric    = 1'b1;
        case (record_type_reg)
            dtlv_pkg::TYPE_LAT:     begin field_size = 3'd4; field_kind = dtlv_pkg::KIND_LAT;     end
            dtlv_pkg::TYPE_LON:     begin field_size = 3'd4; field_kind = dtlv_pkg::KIND_LON;     end
            dtlv_pkg::TYPE_ALT:     begin field_size = 3'd2; field_kind = dtlv_pkg::KIND_ALT;     end
            dtlv_pkg::TYPE_HEIGHT:  begin field_size = 3'd2; field_kind = dtlv_pkg::KIND_HEIGHT;  end
            dtlv_pkg::TYPE_OPLAT:   begin field_size = 3'd4; field_kind = dtlv_pkg::KIND_OPLAT;   end
            dtlv_pkg::TYPE_OPLON:   begin field_size = 3'd4; field_kind = dtlv_pkg::KIND_OPLON;   end
            dtlv_pkg::TYPE_SPEED:   begin field_size = 3'd1; field_kind = dtlv_pkg::KIND_SPEED;   end
            dtlv_pkg::TYPE_HEADING: begin field_size = 3'd2; field_kind = dtlv_pkg::KIND_HEADING; end
            default:                numeric = 1'b0;
        endcase

        // Value byte decode
        val_hit   = 1'b0;
        val_kind  = dtlv_pkg::KIND_OPID;
        val_index = 5'd0;
        val_value = {24'd0, beat.data_byte};
        if (phase_reg == dtlv_pkg::PHASE_VALUE)
        begin
            if (record_type_reg == dtlv_pkg::TYPE_OPID)
            begin
                val_hit   = (value_position_reg >= 8'd6) && (vp_char < IdLimit);
                val_kind  = dtlv_pkg::KIND_OPID;
                val_index = vp_char[4:0];
            end
            else if (record_type_reg == dtlv_pkg::TYPE_UAVID)
            begin
                val_hit   = value_position_reg < IdLimit;
                val_kind  = dtlv_pkg::KIND_UAVID;
                val_index = value_position_reg[4:0];
            end
            else if (numeric)
            begin
                val_hit  = value_position_reg == {5'd0, field_size - 3'd1};
                val_kind = field_kind;
                case (field_kind)
                    dtlv_pkg::KIND_ALT, dtlv_pkg::KIND_HEIGHT:
                        val_value = {{16{shifted[15]}}, shifted[15:0]};
                    dtlv_pkg::KIND_SPEED:   val_value = {24'd0, shifted[7:0]};
                    dtlv_pkg::KIND_HEADING: val_value = {16'd0, shifted[15:0]};
                    default:                val_value = shifted;
                endcase
            end
        end

        // State update
        byte_offset_next       = (byte_offset_reg == 8'hFF) ? byte_offset_reg
                                                            : byte_offset_reg + 8'd1;
        element_length_next    = len_eff;
        next_record_start_next = next_record_start_reg;
        record_type_next       = record_type_reg;
        record_length_next     = record_length_reg;
        value_position_next    = value_position_reg;
        field_shift_next       = field_shift_reg;
        phase_next             = phase_reg;
        case (phase_reg)
            dtlv_pkg::PHASE_GAP:
            begin
                if (byte_offset_reg >= dtlv_pkg::FIRST_RECORD &&
                    {1'b0, byte_offset_reg} == next_record_start_reg &&
                    byte_offset_reg < len_eff)
                begin
                    record_type_next = beat.data_byte;
                    phase_next       = dtlv_pkg::PHASE_TYPE;
                end
            end
            dtlv_pkg::PHASE_TYPE:
            begin
                record_length_next     = beat.data_byte;
                next_record_start_next = next_record_start_reg + {1'b0, beat.data_byte} + 9'd2;
                value_position_next    = 8'd0;
                field_shift_next       = 32'd0;
                phase_next             = (beat.data_byte != 8'd0) ? dtlv_pkg::PHASE_VALUE
                                                                  : dtlv_pkg::PHASE_GAP;
            end
            default:
            begin
                if (numeric && value_position_reg < {5'd0, field_size})
                    field_shift_next = shifted;
                value_position_next = vp_inc;
                if (vp_inc >= record_length_reg)
                    phase_next = dtlv_pkg::PHASE_GAP;
            end
        endcase

        // Drop everything back to reset at the end of the element
        if (beat.final_byte)
        begin
            byte_offset_next       = 8'd0;
            element_length_next    = 8'd0;
            next_record_start_next = {1'b0, dtlv_pkg::FIRST_RECORD};
            record_type_next       = 8'd0;
            record_length_next     = 8'd0;
            value_position_next    = 8'd0;
            field_shift_next       = 32'd0;
            phase_next             = dtlv_pkg::PHASE_GAP;
        end

        val_res.kind       = val_kind;
        val_res.char_index = val_hit ? val_index : 5'd0;
        val_res.value      = val_value;
        val_res.run_end    = ~beat.final_byte;
        end_res.kind       = dtlv_pkg::KIND_END;
        end_res.char_index = 5'd0;
        end_res.value      = 32'sd0;
        end_res.run_end    = 1'b1;

        emit.count  = 2'({1'b0, val_hit} + {1'b0, beat.final_byte});
        emit.first  = val_hit ? val_res : end_res;
        emit.second = end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg       <= 8'd0;
            element_length_reg    <= 8'd0;
            next_record_start_reg <= {1'b0, dtlv_pkg::FIRST_RECORD};
            record_type_reg       <= 8'd0;
            record_length_reg     <= 8'd0;
            value_position_reg    <= 8'd0;
            field_shift_reg       <= 32'd0;
            phase_reg             <= dtlv_pkg::PHASE_GAP;
        end
        else if (accept)
        begin
            byte_offset_reg       <= byte_offset_next;
            element_length_reg    <= element_length_next;
            next_record_start_reg <= next_record_start_next;
            record_type_reg       <= record_type_next;
            record_length_reg     <= record_length_next;
            value_position_reg    <= value_position_next;
            field_shift_reg       <= field_shift_next;
            phase_reg             <= phase_next;
        end
    end

    // A final byte leaves the parser in its reset state
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && beat.final_byte |=> byte_offset_reg == 8'd0 &&
                                      phase_reg == dtlv_pkg::PHASE_GAP)
        else $error("parser state not cleared after final byte");

    // Two results only come from a final byte
    a_two_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        emit.count == 2'd2 |-> beat.final_byte)
        else $error("two results without final byte");

    // Value bytes are only seen with a nonzero record length
    a_value_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dtlv_pkg::PHASE_VALUE |-> record_length_reg != 8'd0)
        else $error("value phase with empty record");

endmodule

/* sv/dtlv_queue.sv */
// Small result queue: takes up to two results a beat, hands out one a beat.
// Depends on dtlv_pkg.
module dtlv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  dtlv_pkg::emit_t  push,
    output logic             space_low,
    output logic             res_valid,
    input  logic             res_stall,
    output dtlv_pkg::out_t   res_beat
);

    localparam int Depth = dtlv_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    dtlv_pkg::out_t mem [Depth];

    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      push_n;
    logic            pop;

    always_comb
    begin
        push_n     = push_en ? push.count : 2'd0;
        pop        = res_valid && !res_stall;
        wr_next    = wr_reg + PtrW'(push_n);
        rd_next    = rd_reg + PtrW'(pop);
        count_next = count_reg + CntW'(push_n) - CntW'(pop);
    end

    assign res_valid = count_reg != '0;
    assign res_beat  = mem[rd_reg];
    // Hold input off unless two free entries remain
    assign space_low = count_reg > CntW'(Depth - 2);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_reg] <= push.first;
        if (push_n == 2'd2)
            mem[wr_reg + PtrW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> !space_low)
        else $error("push while queue short of space");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_reg == rd_reg)
        else $error("empty queue with pointers apart");

endmodule

/* sv/drone_id_tlv_element_parser.sv */
// Top level of the drone ID element parser: byte channel in, result channel out.
// Depends on dtlv_pkg, dtlv_core and dtlv_queue.
//
//   channel   direction   beat type          handshake
//   byte      in          dtlv_pkg::in_t     byte_valid / byte_stall
//   res       out         dtlv_pkg::out_t    res_valid  / res_stall
//
// One byte is taken per cycle when byte_stall is low; its results enter a 4-entry
// queue the same edge and the first can leave on the next cycle. Sustained rate
// is one byte per cycle while the queue drains; the final byte adds one extra
// result beat. byte_stall rises when fewer than two queue entries are free.
// Reset (rst_n, asynchronous) empties the queue and returns the parser to offset 0.
module drone_id_tlv_element_parser #(
    parameter int ID_CHARS = dtlv_pkg::ID_CHARS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  dtlv_pkg::in_t   byte_beat,
    output logic            res_valid,
    input  logic            res_stall,
    output dtlv_pkg::out_t  res_beat
);

    logic            accept;
    dtlv_pkg::emit_t emit;

    assign accept = byte_valid && !byte_stall;

    dtlv_core #(
        .ID_CHARS (ID_CHARS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (byte_beat),
        .emit   (emit)
    );

    dtlv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (emit),
        .space_low (byte_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

/* tb/drone_id_tlv_element_parser_tb.sv */
// Self-checking testbench for drone_id_tlv_element_parser: drives whole elements byte by byte
// and checks every result beat against a built-in record decoder.
// Depends on dtlv_pkg and the RTL of the parser only.
module drone_id_tlv_element_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_CHARS = dtlv_pkg::ID_CHARS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_BYTES = 650;
    localparam int IDLE_PLAN [4] = '{0, 50, 0, 26};
    localparam int STALL_PLAN [4] = '{0, 0, 50, 26};

    typedef enum int {SHAPE_WELL, SHAPE_LONG, SHAPE_NOISE} shape_t;

    // Decodes the element the same way the parser must and holds the results still owed.
    class element_scoreboard;
        dtlv_pkg::out_t due[$];
        int          faults;
        logic [7:0]  offset;
        logic [7:0]  elem_len;
        logic [8:0]  next_start;
        logic [7:0]  rec_type;
        logic [7:0]  rec_len;
        logic [7:0]  val_pos;
        logic [31:0] shift;
        logic [1:0]  phase;

        function new();
            faults = 0;
            reset_state();
        endfunction

        function void reset_state();
            offset = '0;
            elem_len = '0;
            next_start = {1'b0, dtlv_pkg::FIRST_RECORD};
            rec_type = '0;
            rec_len = '0;
            val_pos = '0;
            shift = '0;
            phase = dtlv_pkg::PHASE_GAP;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void take_byte(dtlv_pkg::in_t beat);
            dtlv_pkg::out_t found[$];
            dtlv_pkg::out_t r;
            logic [7:0] b;
            int         vp;
            int         size;
            logic [3:0] k;
            b = beat.data_byte;
            vp = val_pos;
            size = 0;
            k = dtlv_pkg::KIND_END;
            if (offset == 8'd1)
                elem_len = b;
            case (phase)
                dtlv_pkg::PHASE_GAP:
                begin
                    if (offset >= dtlv_pkg::FIRST_RECORD && {1'b0, offset} == next_start
                        && offset < elem_len)
                    begin
                        rec_type = b;
                        phase = dtlv_pkg::PHASE_TYPE;
                    end
                end
                dtlv_pkg::PHASE_TYPE:
                begin
                    rec_len = b;
                    next_start = next_start + {1'b0, b} + 9'd2;
                    val_pos = '0;
                    shift = '0;
                    phase = (b != 8'd0) ? dtlv_pkg::PHASE_VALUE : dtlv_pkg::PHASE_GAP;
                end
                default:
                begin
                    r = '0;
                    case (rec_type)
                        dtlv_pkg::TYPE_OPID:
                        begin
                            if (vp >= 6 && vp - 6 < ID_CHARS)
                            begin
                                r.kind = dtlv_pkg::KIND_OPID;
                                r.char_index = 5'(vp - 6);
                                r.value = {24'd0, b};
                                found.push_back(r);
                            end
                        end
                        dtlv_pkg::TYPE_UAVID:
                        begin
                            if (vp < ID_CHARS)
                            begin
                                r.kind = dtlv_pkg::KIND_UAVID;
                                r.char_index = 5'(vp);
                                r.value = {24'd0, b};
                                found.push_back(r);
                            end
                        end
                        dtlv_pkg::TYPE_LAT:     begin size = 4; k = dtlv_pkg::KIND_LAT;     end
                        dtlv_pkg::TYPE_LON:     begin size = 4; k = dtlv_pkg::KIND_LON;     end
                        dtlv_pkg::TYPE_ALT:     begin size = 2; k = dtlv_pkg::KIND_ALT;     end
                        dtlv_pkg::TYPE_HEIGHT:  begin size = 2; k = dtlv_pkg::KIND_HEIGHT;  end
                        dtlv_pkg::TYPE_OPLAT:   begin size = 4; k = dtlv_pkg::KIND_OPLAT;   end
                        dtlv_pkg::TYPE_OPLON:   begin size = 4; k = dtlv_pkg::KIND_OPLON;   end
                        dtlv_pkg::TYPE_SPEED:   begin size = 1; k = dtlv_pkg::KIND_SPEED;   end
                        dtlv_pkg::TYPE_HEADING: begin size = 2; k = dtlv_pkg::KIND_HEADING; end
                        default: ;
                    endcase
                    if (size != 0 && vp < size)
                    begin
                        shift = {shift[23:0], b};
                        if (vp == size - 1)
                        begin
                            r.kind = k;
                            r.char_index = '0;
                            if (k == dtlv_pkg::KIND_ALT || k == dtlv_pkg::KIND_HEIGHT)
                                r.value = {{16{shift[15]}}, shift[15:0]};
                            else if (k == dtlv_pkg::KIND_SPEED)
                                r.value = {24'd0, shift[7:0]};
                            else if (k == dtlv_pkg::KIND_HEADING)
                                r.value = {16'd0, shift[15:0]};
                            else
                                r.value = shift;
                            found.push_back(r);
                        end
                    end
                    val_pos = val_pos + 8'd1;
                    if (val_pos >= rec_len)
                        phase = dtlv_pkg::PHASE_GAP;
                end
            endcase
            if (offset < 8'd255)
                offset = offset + 8'd1;
            if (beat.final_byte)
            begin
                r = '0;
                r.kind = dtlv_pkg::KIND_END;
                found.push_back(r);
                reset_state();
            end
            if (found.size() > 0)
                found[found.size() - 1].run_end = 1'b1;
            foreach (found[i])
                due.push_back(found[i]);
        endfunction

        function void check_result(dtlv_pkg::out_t got);
            dtlv_pkg::out_t exp;
            if (due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: kind=%0d idx=%0d value=%0d run_end=%0b",
                             got.kind, got.char_index, got.value, got.run_end);
                return;
            end
            exp = due.pop_front();
            if (got.kind !== exp.kind || got.char_index !== exp.char_index
                || got.value !== exp.value || got.run_end !== exp.run_end)
            begin
                faults++;
                if (faults <= 10)
                    $display({"result mismatch: expected kind=%0d idx=%0d value=%0d run_end=%0b,",
                              " got kind=%0d idx=%0d value=%0d run_end=%0b"},
                             exp.kind, exp.char_index, exp.value, exp.run_end,
                             got.kind, got.char_index, got.value, got.run_end);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic byte_valid;
    logic byte_stall;
    dtlv_pkg::in_t  byte_beat;
    logic res_valid;
    logic res_stall = 1'b0;
    dtlv_pkg::out_t res_beat;

    element_scoreboard sb = new();
    logic [7:0] elem_bytes[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int cycles = 0;

    // Header, then latitude at its most negative, an empty speed record,
    // a one-byte altitude (too short to report) and a full-scale heading.
    logic [7:0] opening_element [21] = '{8'hDD, 8'd19, 8'h6A, 8'h5C, 8'h35, 8'h01,
                                         dtlv_pkg::TYPE_LAT, 8'd4,
                                         8'h80, 8'h00, 8'h00, 8'h00,
                                         dtlv_pkg::TYPE_SPEED, 8'd0,
                                         dtlv_pkg::TYPE_ALT, 8'd1, 8'hFF,
                                         dtlv_pkg::TYPE_HEADING, 8'd2, 8'hFF, 8'hFF};

    drone_id_tlv_element_parser #(
        .ID_CHARS (ID_CHARS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_beat   (res_beat)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_beat);

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(logic [7:0] d, logic fin);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_beat = '{data_byte: d, final_byte: fin};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.take_byte(byte_beat);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_element();
        foreach (elem_bytes[i])
            send_byte(elem_bytes[i], i == elem_bytes.size() - 1);
    endtask

    // Hold the byte channel until every owed result has come out.
    task automatic drain_results();
        byte_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic build_element(shape_t shape);
        int         target;
        int         len;
        int         size;
        logic [7:0] rt;
        elem_bytes.delete();
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 30))
                elem_bytes.push_back(8'($urandom));
            return;
        end
        elem_bytes.push_back(8'($urandom));
        elem_bytes.push_back(8'd0);
        repeat (4)
            elem_bytes.push_back(8'($urandom));
        target = (shape == SHAPE_LONG) ? 265 : $urandom_range(8, 40);
        while (elem_bytes.size() < target)
        begin
            if ($urandom_range(0, 9) < 8)
                rt = 8'($urandom_range(dtlv_pkg::TYPE_OPID, dtlv_pkg::TYPE_HEADING));
            else
                rt = 8'($urandom);
            case (rt)
                dtlv_pkg::TYPE_OPID, dtlv_pkg::TYPE_UAVID: size = 0;
                dtlv_pkg::TYPE_LAT, dtlv_pkg::TYPE_LON,
                dtlv_pkg::TYPE_OPLAT, dtlv_pkg::TYPE_OPLON: size = 4;
                dtlv_pkg::TYPE_ALT, dtlv_pkg::TYPE_HEIGHT,
                dtlv_pkg::TYPE_HEADING: size = 2;
                dtlv_pkg::TYPE_SPEED: size = 1;
                default: size = -1;
            endcase
            if (size == 0)
                len = $urandom_range(0, 32);
            else if (size < 0)
                len = $urandom_range(0, 8);
            else if ($urandom_range(0, 4) == 0)
                len = $urandom_range(0, size + 3);
            else
                len = size;
            elem_bytes.push_back(rt);
            elem_bytes.push_back(8'(len));
            repeat (len)
                elem_bytes.push_back(pick_byte());
        end
        // Length byte: mostly true, sometimes short of or past the records.
        if (shape == SHAPE_LONG)
            elem_bytes[1] = 8'd255;
        else
            case ($urandom_range(0, 9))
                0: elem_bytes[1] = 8'($urandom);
                1: elem_bytes[1] = 8'(elem_bytes.size() - 2 - $urandom_range(1, 6));
                default: elem_bytes[1] = 8'(elem_bytes.size() - 2);
            endcase
        // Cut some elements off in the middle of a record.
        if (shape == SHAPE_WELL && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                void'(elem_bytes.pop_back());
    endtask

    initial
    begin
        int budget;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_beat = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        elem_bytes.delete();
        foreach (opening_element[i])
            elem_bytes.push_back(opening_element[i]);
        send_element();
        // One-byte elements: the end beat arrives with nothing parsed.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            // Split what is left of the byte total over the remaining phases.
            budget = bytes_sent + (TOTAL_BYTES - bytes_sent) / (4 - p);
            if (p == 0)
            begin
                build_element(SHAPE_LONG);
                send_element();
            end
            while (bytes_sent < budget)
            begin
                build_element(($urandom_range(0, 9) == 0) ? SHAPE_NOISE : SHAPE_WELL);
                send_element();
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (16)
            @(posedge clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/dtlv_pkg.sv
sv/dtlv_core.sv
sv/dtlv_queue.sv
sv/drone_id_tlv_element_parser.sv
tb/drone_id_tlv_element_parser_tb.sv
